### hdl/sfs_pkg.sv
package sfs_pkg;

    // Command field of an input item
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_FORCE   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_LOAD    = 2'd3
    } t_command;

    // Playback modes
    typedef enum logic [1:0] {
        MODE_LOOP          = 2'd0,
        MODE_ONCE          = 2'd1,
        MODE_PINGPONG      = 2'd2,
        MODE_PINGPONG_ONCE = 2'd3
    } t_anim_mode;

    // Configuration register indexes
    localparam logic CFG_ANIM_MODE   = 1'b0;
    localparam logic CFG_FRAME_COUNT = 1'b1;

    localparam int MODE_BITS      = 2;
    localparam int COUNT_BITS     = 7;
    localparam int CFG_DATA_BITS  = 7;
    localparam int TIME_BITS      = 16;
    localparam int ACCUM_BITS     = 32;
    localparam int INDEX_BITS     = 6;

endpackage

### hdl/sprite_frame_sequencer.sv
// Sprite animation frame sequencer.
// Input channel (i_in_valid / o_in_ready) carries one command per transfer:
// tick with elapsed time, force frame, restart, or load of a frame table entry.
// Output channel (o_out_valid / i_out_ready) returns exactly one result per
// command: current frame, displayed rectangle, update / done / rejected flags.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes the
// playback mode (index 0) or the frame count (index 1); write only when idle.
// Each command passes through the input register, then the result register.
// Throughput is one command per cycle while the receiver takes every result;
// the frame table is a single-write, single-read memory whose read address
// always follows the current frame, so its registered read data (with write
// forwarding) always holds the current entry's time and rectangle.
// Reset clears frame, accumulator, direction, finished flag, displayed
// rectangle and configuration; the frame table is not cleared.
// When the receiver stalls, the result register holds, the execute stage
// waits, and the input register fills once before o_in_ready drops.
module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [sfs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // command input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_command,
    input  logic [sfs_pkg::TIME_BITS-1:0]      i_elapsed,
    input  logic [sfs_pkg::INDEX_BITS-1:0]     i_frame_index,
    input  logic [COORD_BITS-1:0]              i_rect_x,
    input  logic [COORD_BITS-1:0]              i_rect_y,
    input  logic [COORD_BITS-1:0]              i_rect_w,
    input  logic [COORD_BITS-1:0]              i_rect_h,
    input  logic [sfs_pkg::TIME_BITS-1:0]      i_frame_time,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [sfs_pkg::INDEX_BITS-1:0]     o_shown_frame,
    output logic [COORD_BITS-1:0]              o_out_x,
    output logic [COORD_BITS-1:0]              o_out_y,
    output logic [COORD_BITS-1:0]              o_out_w,
    output logic [COORD_BITS-1:0]              o_out_h,
    output logic                               o_rect_update,
    output logic                               o_done_res,
    output logic                               o_rejected
);

    localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW0 = $clog2(MAX_FRAMES + 1);
    // compare width for counts and indexes
    localparam int NW  = (CW0 > sfs_pkg::COUNT_BITS) ? CW0 : sfs_pkg::COUNT_BITS;
    localparam int TB  = sfs_pkg::TIME_BITS;
    localparam int AB  = sfs_pkg::ACCUM_BITS;
    localparam int EW  = 4 * COORD_BITS + TB;   // entry: {time, h, w, y, x}

    // ---------------- configuration ----------------
    sfs_pkg::t_anim_mode              r_mode;
    logic [sfs_pkg::COUNT_BITS-1:0]   r_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sfs_pkg::MODE_LOOP;
            r_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfs_pkg::CFG_ANIM_MODE:
                    r_mode <= sfs_pkg::t_anim_mode'(i_cfg_data[sfs_pkg::MODE_BITS-1:0]);
                sfs_pkg::CFG_FRAME_COUNT:
                    r_count <= i_cfg_data[sfs_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                            r_in_valid;
    sfs_pkg::t_command               r_in_cmd;
    logic [TB-1:0]                   r_in_elapsed;
    logic [sfs_pkg::INDEX_BITS-1:0]  r_in_idx;
    logic [EW-1:0]                   r_in_entry;

    logic r_res_valid;
    logic e_go;

    assign e_go       = r_in_valid && (!r_res_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || e_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd     <= sfs_pkg::t_command'(i_command);
            r_in_elapsed <= i_elapsed;
            r_in_idx     <= i_frame_index;
            r_in_entry   <= {i_frame_time, i_rect_h, i_rect_w, i_rect_y, i_rect_x};
        end
    end

    // ---------------- frame table ----------------
    logic [EW-1:0]  r_mem [MAX_FRAMES];
    logic [EW-1:0]  r_rd_mem;
    logic [EW-1:0]  r_byp_data;
    logic           r_byp_hit;
    logic [EW-1:0]  rd_entry;
    logic           mem_we;
    logic [FW-1:0]  mem_waddr;

    // playback state
    logic [FW-1:0]  r_cur, n_cur;
    logic [AB-1:0]  r_acc, n_acc;
    logic           r_back, n_back;
    logic           r_fin, n_fin;

    assign mem_waddr = FW'(r_in_idx);

    // read address always tracks the frame that is current after this cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_in_entry;
        end
        r_rd_mem <= r_mem[n_cur];
    end

    // write-to-read forwarding for a load of the frame being read
    always_ff @(posedge i_clk) begin
        r_byp_hit  <= mem_we && (mem_waddr == n_cur);
        r_byp_data <= r_in_entry;
    end

    assign rd_entry = r_byp_hit ? r_byp_data : r_rd_mem;

    // ---------------- execute ----------------
    logic [NW-1:0]  act_n;
    logic [NW-1:0]  last_n;
    logic [NW-1:0]  idx_n;
    logic [NW-1:0]  nx;
    logic [AB:0]    sum;
    logic [AB-1:0]  acc_sat;
    logic [AB-1:0]  delay;
    logic [FW-1:0]  adv_frame;
    logic           adv_back;
    logic           adv_fin;
    logic           e_upd;
    logic           e_rej;

    assign act_n  = (NW'(r_count) > NW'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : NW'(r_count);
    assign last_n = act_n - NW'(1);
    assign idx_n  = NW'(r_in_idx);
    assign delay  = AB'(rd_entry[EW-1 -: TB]);
    assign sum    = {1'b0, r_acc} + (AB + 1)'(r_in_elapsed);
    assign acc_sat = sum[AB] ? '1 : sum[AB-1:0];

    // one step of the sequence by the mode's rule
    always_comb begin
        adv_frame = r_cur;
        adv_back  = r_back;
        adv_fin   = r_fin;
        nx        = r_back ? (NW'(r_cur) - NW'(1)) : (NW'(r_cur) + NW'(1));
        if (r_back && (r_cur == '0)) begin
            // stepped below the first frame
            unique case (r_mode) inside
                sfs_pkg::MODE_LOOP: begin
                    adv_frame = last_n[FW-1:0];
                end
                sfs_pkg::MODE_PINGPONG: begin
                    adv_frame = '0;
                    adv_back  = 1'b0;
                end
                sfs_pkg::MODE_ONCE, sfs_pkg::MODE_PINGPONG_ONCE: begin
                    adv_frame = '0;
                    adv_fin   = 1'b1;
                end
                default: ;
            endcase
        end else if (nx >= act_n) begin
            // stepped past the last frame (also after the count was lowered)
            unique case (r_mode) inside
                sfs_pkg::MODE_LOOP: begin
                    adv_frame = '0;
                end
                sfs_pkg::MODE_ONCE: begin
                    adv_frame = last_n[FW-1:0];
                    adv_fin   = 1'b1;
                end
                sfs_pkg::MODE_PINGPONG, sfs_pkg::MODE_PINGPONG_ONCE: begin
                    adv_frame = last_n[FW-1:0];
                    adv_back  = 1'b1;
                end
                default: ;
            endcase
        end else begin
            adv_frame = nx[FW-1:0];
        end
    end

    always_comb begin
        n_cur  = r_cur;
        n_acc  = r_acc;
        n_back = r_back;
        n_fin  = r_fin;
        e_upd  = 1'b0;
        e_rej  = 1'b0;
        mem_we = 1'b0;
        if (e_go) begin
            unique case (r_in_cmd)
                sfs_pkg::CMD_TICK: begin
                    if ((act_n != '0) && !r_fin) begin
                        n_acc = acc_sat;
                        if (acc_sat >= delay) begin
                            n_cur  = adv_frame;
                            n_back = adv_back;
                            n_fin  = adv_fin;
                            n_acc  = acc_sat - delay;
                            e_upd  = 1'b1;
                        end
                    end
                end
                sfs_pkg::CMD_FORCE: begin
                    if (idx_n >= act_n) begin
                        e_rej = 1'b1;
                    end else begin
                        n_cur = idx_n[FW-1:0];
                        n_acc = '0;
                        e_upd = 1'b1;
                    end
                end
                sfs_pkg::CMD_RESTART: begin
                    n_cur  = '0;
                    n_acc  = '0;
                    n_back = 1'b0;
                    n_fin  = 1'b0;
                    e_upd  = (act_n != '0);
                end
                sfs_pkg::CMD_LOAD: begin
                    mem_we = (idx_n < NW'(MAX_FRAMES));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_acc  <= '0;
            r_back <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_cur  <= n_cur;
            r_acc  <= n_acc;
            r_back <= n_back;
            r_fin  <= n_fin;
        end
    end

    // ---------------- result register ----------------
    logic [sfs_pkg::INDEX_BITS-1:0]  r_res_frame;
    logic                            r_res_upd;
    logic                            r_res_done;
    logic                            r_res_rej;
    logic [COORD_BITS-1:0]           r_shown_x, r_shown_y, r_shown_w, r_shown_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (e_go) begin
            r_res_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_go) begin
            r_res_frame <= sfs_pkg::INDEX_BITS'(n_cur);
            r_res_upd   <= e_upd;
            r_res_done  <= n_fin;
            r_res_rej   <= e_rej;
        end
    end

    // the table read for an updating item lands while its result is held,
    // and stays put until that result leaves
    assign o_out_x = r_res_upd ? rd_entry[0*COORD_BITS +: COORD_BITS] : r_shown_x;
    assign o_out_y = r_res_upd ? rd_entry[1*COORD_BITS +: COORD_BITS] : r_shown_y;
    assign o_out_w = r_res_upd ? rd_entry[2*COORD_BITS +: COORD_BITS] : r_shown_w;
    assign o_out_h = r_res_upd ? rd_entry[3*COORD_BITS +: COORD_BITS] : r_shown_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown_x <= '0;
            r_shown_y <= '0;
            r_shown_w <= '0;
            r_shown_h <= '0;
        end else if (r_res_valid && i_out_ready) begin
            r_shown_x <= o_out_x;
            r_shown_y <= o_out_y;
            r_shown_w <= o_out_w;
            r_shown_h <= o_out_h;
        end
    end

    assign o_out_valid   = r_res_valid;
    assign o_shown_frame = r_res_frame;
    assign o_rect_update = r_res_upd;
    assign o_done_res    = r_res_done;
    assign o_rejected    = r_res_rej;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int FRAMES        = 64;
    localparam int COORD         = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 20;

    // One command as offered on the input channel
    typedef struct packed {
        sfs_pkg::t_command cmd;
        logic [15:0]       elapsed;
        logic [5:0]        index;
        logic [COORD-1:0]  x;
        logic [COORD-1:0]  y;
        logic [COORD-1:0]  w;
        logic [COORD-1:0]  h;
        logic [15:0]       ftime;
    } t_anim_cmd;

    // What the block should show after one command
    typedef struct packed {
        logic [5:0]        frame;
        logic [COORD-1:0]  x;
        logic [COORD-1:0]  y;
        logic [COORD-1:0]  w;
        logic [COORD-1:0]  h;
        logic              upd;
        logic              done;
        logic              rej;
    } t_frame_view;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = sfs_pkg::CFG_ANIM_MODE;
    logic [6:0]        i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_command   = sfs_pkg::CMD_TICK;
    logic [15:0]       i_elapsed   = '0;
    logic [5:0]        i_frame_index = '0;
    logic [COORD-1:0]  i_rect_x    = '0;
    logic [COORD-1:0]  i_rect_y    = '0;
    logic [COORD-1:0]  i_rect_w    = '0;
    logic [COORD-1:0]  i_rect_h    = '0;
    logic [15:0]       i_frame_time = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [5:0]        o_shown_frame;
    logic [COORD-1:0]  o_out_x;
    logic [COORD-1:0]  o_out_y;
    logic [COORD-1:0]  o_out_w;
    logic [COORD-1:0]  o_out_h;
    logic              o_rect_update;
    logic              o_done_res;
    logic              o_rejected;

    sprite_frame_sequencer #(
        .MAX_FRAMES (FRAMES),
        .COORD_BITS (COORD)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_elapsed     (i_elapsed),
        .i_frame_index (i_frame_index),
        .i_rect_x      (i_rect_x),
        .i_rect_y      (i_rect_y),
        .i_rect_w      (i_rect_w),
        .i_rect_h      (i_rect_h),
        .i_frame_time  (i_frame_time),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_shown_frame (o_shown_frame),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_w       (o_out_w),
        .o_out_h       (o_out_h),
        .o_rect_update (o_rect_update),
        .o_done_res    (o_done_res),
        .o_rejected    (o_rejected)
    );

    // ------------------------------------------------------------------
    // Playback model: own copy of the frame table, playhead and settings
    // ------------------------------------------------------------------
    logic [COORD-1:0]  tbl_x [FRAMES];
    logic [COORD-1:0]  tbl_y [FRAMES];
    logic [COORD-1:0]  tbl_w [FRAMES];
    logic [COORD-1:0]  tbl_h [FRAMES];
    logic [15:0]       tbl_time [FRAMES];
    logic [5:0]        cur_frame = '0;
    logic [31:0]       accum     = '0;
    logic              backward  = 1'b0;
    logic              finished  = 1'b0;
    sfs_pkg::t_anim_mode mode_q  = sfs_pkg::MODE_LOOP;
    logic [6:0]        count_q   = '0;
    logic [COORD-1:0]  disp_x = '0, disp_y = '0, disp_w = '0, disp_h = '0;

    t_frame_view       expected_views[$];
    int                fail_count    = 0;
    int                cycle_count   = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                recv_hold     = 0;

    task automatic show_frame();
        disp_x = tbl_x[cur_frame];
        disp_y = tbl_y[cur_frame];
        disp_w = tbl_w[cur_frame];
        disp_h = tbl_h[cur_frame];
    endtask

    // Apply one command to the model and return the view it leaves behind
    task automatic play_command(input t_anim_cmd it, output t_frame_view v);
        int          n;
        int          nxt;
        logic [32:0] acc_sum;
        logic [15:0] delay;
        n = (count_q > 7'd64) ? FRAMES : int'(count_q);
        v.upd = 1'b0;
        v.rej = 1'b0;
        case (it.cmd)
            sfs_pkg::CMD_TICK: begin
                // idle when no frames are in use or a once mode has run out
                if (n != 0 && !finished) begin
                    delay   = tbl_time[cur_frame];
                    acc_sum = {1'b0, accum} + 33'(it.elapsed);
                    accum   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                    if (accum >= 32'(delay)) begin
                        nxt = int'(cur_frame) + (backward ? -1 : 1);
                        // a playhead left beyond a lowered count ends here too
                        if (nxt >= n) begin
                            if (mode_q == sfs_pkg::MODE_LOOP) begin
                                nxt = 0;
                            end else begin
                                nxt = n - 1;
                                if (mode_q == sfs_pkg::MODE_ONCE) finished = 1'b1;
                                else backward = 1'b1;
                            end
                        end else if (nxt < 0) begin
                            if (mode_q == sfs_pkg::MODE_LOOP) begin
                                nxt = n - 1;
                            end else begin
                                nxt = 0;
                                if (mode_q == sfs_pkg::MODE_PINGPONG) backward = 1'b0;
                                else finished = 1'b1;
                            end
                        end
                        cur_frame = 6'(nxt);
                        show_frame();
                        v.upd = 1'b1;
                        accum = accum - 32'(delay);
                    end
                end
            end
            sfs_pkg::CMD_FORCE: begin
                if (int'(it.index) >= n) begin
                    v.rej = 1'b1;
                end else begin
                    cur_frame = it.index;
                    accum     = '0;
                    show_frame();
                    v.upd = 1'b1;
                end
            end
            sfs_pkg::CMD_RESTART: begin
                cur_frame = '0;
                accum     = '0;
                finished  = 1'b0;
                backward  = 1'b0;
                if (n != 0) begin
                    show_frame();
                    v.upd = 1'b1;
                end
            end
            default: begin
                // table load; the picture on display stays as is
                tbl_x[it.index]    = it.x;
                tbl_y[it.index]    = it.y;
                tbl_w[it.index]    = it.w;
                tbl_h[it.index]    = it.h;
                tbl_time[it.index] = it.ftime;
            end
        endcase
        v.frame = cur_frame;
        v.x     = disp_x;
        v.y     = disp_y;
        v.w     = disp_w;
        v.h     = disp_h;
        v.done  = finished;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_anim_cmd random_command();
        t_anim_cmd it;
        int        n;
        int        r;
        n = (count_q > 7'd64) ? FRAMES : int'(count_q);
        r = $urandom_range(99);
        it.elapsed = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        it.index   = 6'($urandom);
        it.x       = COORD'($urandom);
        it.y       = COORD'($urandom);
        it.w       = COORD'($urandom);
        it.h       = COORD'($urandom);
        it.ftime   = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(30));
        // mostly ticks so the playhead actually travels through the modes
        if (r < 60) begin
            it.cmd = sfs_pkg::CMD_TICK;
        end else if (r < 72) begin
            it.cmd = sfs_pkg::CMD_LOAD;
        end else if (r < 87) begin
            it.cmd = sfs_pkg::CMD_FORCE;
            if (n > 0 && $urandom_range(3) != 0) it.index = 6'($urandom_range(n - 1));
        end else begin
            it.cmd = sfs_pkg::CMD_RESTART;
        end
        return it;
    endfunction

    function automatic t_anim_cmd cmd_of(input sfs_pkg::t_command c,
                                         input int unsigned value,
                                         input int unsigned idx);
        t_anim_cmd it;
        it         = random_command();
        it.cmd     = c;
        it.elapsed = 16'(value);
        it.index   = 6'(idx);
        return it;
    endfunction

    function automatic t_anim_cmd load_of(input int unsigned idx, input int unsigned x,
                                          input int unsigned y, input int unsigned w,
                                          input int unsigned h, input int unsigned t);
        t_anim_cmd it;
        it       = random_command();
        it.cmd   = sfs_pkg::CMD_LOAD;
        it.index = 6'(idx);
        it.x     = COORD'(x);
        it.y     = COORD'(y);
        it.w     = COORD'(w);
        it.h     = COORD'(h);
        it.ftime = 16'(t);
        return it;
    endfunction

    // One input transfer, preceded by a random gap; valid stays up on exit
    task automatic send_command(input t_anim_cmd it);
        t_frame_view want;
        int          gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command     <= it.cmd;
        i_elapsed     <= it.elapsed;
        i_frame_index <= it.index;
        i_rect_x      <= it.x;
        i_rect_y      <= it.y;
        i_rect_w      <= it.w;
        i_rect_h      <= it.h;
        i_frame_time  <= it.ftime;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        play_command(it, want);
        expected_views.insert(expected_views.size(), want);
    endtask

    // Hold the input until every outstanding result has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_views.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // Both registers, written back to back while the block is idle
    task automatic write_config(input sfs_pkg::t_anim_mode m, input logic [6:0] c);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sfs_pkg::CFG_ANIM_MODE;
        i_cfg_data  <= 7'(m);
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        mode_q = m;
        i_cfg_index <= sfs_pkg::CFG_FRAME_COUNT;
        i_cfg_data  <= c;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        count_q = c;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Nothing in use after reset: tick idles, any force is out of range,
    // restart shows nothing
    task automatic test_idle_after_reset();
        send_command(cmd_of(sfs_pkg::CMD_TICK, 16'hFFFF, 0));
        send_command(cmd_of(sfs_pkg::CMD_FORCE, 0, 63));
        send_command(cmd_of(sfs_pkg::CMD_RESTART, 0, 0));
    endtask

    // Every entry is loaded before anything can read the table
    task automatic test_table_fill();
        send_command(load_of(0, 0, 0, 0, 0, 3));
        send_command(load_of(1, 4095, 4095, 4095, 4095, 16'hFFFF));
        send_command(load_of(2, $urandom, $urandom, $urandom, $urandom, 0));
        for (int i = 3; i < FRAMES; i++)
            send_command(load_of(i, $urandom, $urandom, $urandom, $urandom,
                                 $urandom_range(1, 20)));
    endtask

    task automatic test_loop_and_force();
        write_config(sfs_pkg::MODE_LOOP, 7'd4);
        send_command(cmd_of(sfs_pkg::CMD_RESTART, 0, 0));
        send_command(cmd_of(sfs_pkg::CMD_TICK, 5, 0));        // frame 0 lasts 3: step, carry 2
        send_command(cmd_of(sfs_pkg::CMD_TICK, 16'hFFFF, 0)); // longest frame time
        send_command(cmd_of(sfs_pkg::CMD_TICK, 0, 0));        // zero-time frame steps on empty tick
        send_command(cmd_of(sfs_pkg::CMD_TICK, 16'hFFFF, 0)); // wrap to frame 0
        send_command(cmd_of(sfs_pkg::CMD_FORCE, 0, 3));
        send_command(cmd_of(sfs_pkg::CMD_FORCE, 0, 4));       // one past the count
    endtask

    task automatic test_play_once();
        write_config(sfs_pkg::MODE_ONCE, 7'd3);
        send_command(cmd_of(sfs_pkg::CMD_RESTART, 0, 0));
        repeat (3) send_command(cmd_of(sfs_pkg::CMD_TICK, 16'hFFFF, 0));
        send_command(cmd_of(sfs_pkg::CMD_TICK, 16'hFFFF, 0)); // finished: tick changes nothing
    endtask

    // Ping-pong turns at the end; the direction flag survives a mode change
    task automatic test_pingpong_direction();
        write_config(sfs_pkg::MODE_PINGPONG, 7'd3);
        send_command(cmd_of(sfs_pkg::CMD_RESTART, 0, 0));
        repeat (3) send_command(cmd_of(sfs_pkg::CMD_TICK, 16'hFFFF, 0));
        write_config(sfs_pkg::MODE_LOOP, 7'd3);
        repeat (2) send_command(cmd_of(sfs_pkg::CMD_TICK, 16'hFFFF, 0));  // steps backward to frame 0
        write_config(sfs_pkg::MODE_PINGPONG_ONCE, 7'd3);
        repeat (3) send_command(cmd_of(sfs_pkg::CMD_TICK, 16'hFFFF, 0));  // runs out at frame 0
    endtask

    // Playhead left past a lowered count: next step is the end of the run
    task automatic test_count_lowered();
        write_config(sfs_pkg::MODE_ONCE, 7'd10);
        send_command(cmd_of(sfs_pkg::CMD_RESTART, 0, 0));
        send_command(cmd_of(sfs_pkg::CMD_FORCE, 0, 8));
        write_config(sfs_pkg::MODE_ONCE, 7'd4);
        send_command(cmd_of(sfs_pkg::CMD_TICK, 16'hFFFF, 0));
    endtask

    // Receiver holds off for a long stretch while commands keep coming,
    // then the sender waits for every result
    task automatic test_output_stall();
        write_config(sfs_pkg::MODE_PINGPONG, 7'd8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold     = 300;
        repeat (60) send_command(random_command());
        wait_drained();
    endtask

    // Random commands in segments, each under a fresh playback setting
    task automatic test_random(input int total, input int s_pct, input int r_pct);
        int         sent;
        int         seg;
        int         r;
        logic [6:0] c;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < total) begin
            r = $urandom_range(99);
            if (r < 5)       c = 7'd0;
            else if (r < 12) c = 7'd1;
            else if (r < 20) c = 7'd64;
            else if (r < 26) c = 7'($urandom_range(65, 127));
            else if (r < 60) c = 7'($urandom_range(2, 8));
            else             c = 7'($urandom_range(2, 63));
            write_config(sfs_pkg::t_anim_mode'($urandom_range(3)), c);
            seg = $urandom_range(40, 120);
            repeat (seg) send_command(random_command());
            sent += seg;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, receiver, result check, run limit
    // ------------------------------------------------------------------
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Output ready: random stalls, or a counted hold-off when requested
    always @(posedge i_clk) begin
        if (recv_hold > 0) begin
            i_out_ready <= 1'b0;
            recv_hold = recv_hold - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each result transfer is matched against the oldest expected view
    always @(posedge i_clk) begin
        t_frame_view want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_views.size() == 0) begin
                report_mismatch("result transfer with no command outstanding");
            end else begin
                want = expected_views.pop_front();
                check_field("shown_frame", 16'(o_shown_frame), 16'(want.frame));
                check_field("out_x", 16'(o_out_x), 16'(want.x));
                check_field("out_y", 16'(o_out_y), 16'(want.y));
                check_field("out_w", 16'(o_out_w), 16'(want.w));
                check_field("out_h", 16'(o_out_h), 16'(want.h));
                check_field("rect_update", 16'(o_rect_update), 16'(want.upd));
                check_field("done_res", 16'(o_done_res), 16'(want.done));
                check_field("rejected", 16'(o_rejected), 16'(want.rej));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_views.size());
            $display("sprite_frame_sequencer test failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 30;
        test_idle_after_reset();
        test_table_fill();
        test_loop_and_force();
        test_play_once();
        test_pingpong_direction();
        test_count_lowered();
        test_output_stall();

        // busy sender / stalling receiver, then the reverse, then full rate
        test_random(700, 15, 71);
        test_random(700, 71, 15);
        test_random(600, 0, 0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_views.size() == 0) begin
            $display("sprite_frame_sequencer test passed");
        end else begin
            $display("sprite_frame_sequencer test failed");
        end
        $finish;
    end

endmodule
